// ----- rtl/core/mrs_pkg.sv -----
// Shared types, constants and helpers for the modular root shift block.
package mrs_pkg;

	localparam int WORD_W = 64;
	localparam int CNT_W  = 6;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQP,
		ST_REDQ,
		ST_SQQ,
		ST_EUC,
		ST_DIV,
		ST_TMUL,
		ST_REDA,
		ST_REDB,
		ST_FMUL,
		ST_FIN
	} state_t;

	// Control for a serial unit.
	typedef struct packed {
		logic start;
		logic nomod;
	} mrs_ctl_t;

	// Difference of two residues below m, taken modulo m.
	function automatic logic [WORD_W-1:0] sub_mod(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b, input logic [WORD_W-1:0] m);
		logic [WORD_W-1:0] d;
		d = a - b;
		if (a < b) begin
			d = d + m;
		end
		return d;
	endfunction

endpackage

// ----- rtl/core/mrs_mulmod.sv -----
// Bit-serial shift-and-add modular multiplier, one multiplier bit per cycle.
module mrs_mulmod
	import mrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mrs_ctl_t          ctl,
	input  logic [WORD_W-1:0] op_a,
	input  logic [WORD_W-1:0] op_b,
	input  logic [WORD_W-1:0] modulus,
	output logic              done,
	output logic [WORD_W-1:0] result
);

	logic [WORD_W-1:0] acc_q, a_q, b_q, m_q;
	logic              nomod_q, busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W:0]   dbl, sum;
	logic [WORD_W-1:0] s1, s2;

	// Double the accumulator, then add the multiplicand when the bit is set.
	always_comb begin
		dbl = {acc_q, 1'b0};
		s1 = dbl[WORD_W-1:0];
		if (!nomod_q && dbl >= {1'b0, m_q}) begin
			s1 = WORD_W'(dbl - {1'b0, m_q});
		end
		s2 = s1;
		if (b_q[WORD_W-1]) begin
			sum = {1'b0, s1} + {1'b0, a_q};
			s2 = sum[WORD_W-1:0];
			if (!nomod_q && sum >= {1'b0, m_q}) begin
				s2 = WORD_W'(sum - {1'b0, m_q});
			end
		end else begin
			sum = '0;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q   <= '0;
			a_q     <= op_a;
			b_q     <= op_b;
			m_q     <= modulus;
			nomod_q <= ctl.nomod;
		end else if (busy_q) begin
			acc_q <= s2;
			b_q   <= {b_q[WORD_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

// ----- rtl/core/mrs_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module mrs_divider
	import mrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quotient,
	output logic [WORD_W-1:0] remainder
);

	logic [WORD_W-1:0] n_q, d_q, r_q, r_n;
	logic              busy_q, done_q, qbit;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W:0]   trial;

	// Shift in the next dividend bit and subtract when the divisor fits.
	always_comb begin
		trial = {r_q, n_q[WORD_W-1]};
		qbit  = trial >= {1'b0, d_q};
		r_n   = trial[WORD_W-1:0];
		if (qbit) begin
			r_n = WORD_W'(trial - {1'b0, d_q});
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register fills with quotient bits as it empties.
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[WORD_W-2:0], qbit};
			r_q <= r_n;
		end
	end

	assign done      = done_q;
	assign quotient  = n_q;
	assign remainder = r_q;

endmodule

// ----- rtl/core/modular_root_shift_by_inverse_square.sv -----
// Throughput: one word at a time; the next word is accepted once the sequencer is idle,
// while a finished result may still wait in the output register.
// The latency is set by the bit-serial multiplier and divider and by the number of Euclid steps.
// Reset: arst_n clears control state and sets the special-q register to 1; no output is pending.
module modular_root_shift_by_inverse_square
	import mrs_pkg::*;
#(
	parameter int PRIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] prime_p,
	input  logic [63:0] p_root,
	input  logic [63:0] q_root,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] shifted_root,
	output logic        no_inverse
);

	state_t state_q, state_d;
	logic   go_q, go_d;

	logic [31:0]           q_cfg_q;
	logic [PRIME_BITS-1:0] p_q;
	logic [WORD_W-1:0]     pr_q, qr_q, m_q, x_q, r0_q, r1_q, t0_q, t1_q, quo_q, rem_q, res_q;
	logic                  noinv_q;
	logic                  out_valid_q, out_noinv_q;
	logic [WORD_W-1:0]     out_root_q;

	mrs_ctl_t          mul_ctl;
	logic [WORD_W-1:0] mul_a, mul_b, mul_res, div_quo, div_rem, one;
	logic              mul_done, div_done, fin_fire;

	assign one      = (m_q == WORD_W'(1)) ? '0 : WORD_W'(1);
	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = one;
		mul_b = '0;
		mul_ctl.nomod = 1'b0;
		unique case (state_q)
			ST_SQP: begin
				mul_a = WORD_W'(p_q);
				mul_b = WORD_W'(p_q);
				mul_ctl.nomod = 1'b1;
			end
			ST_REDQ: mul_b = WORD_W'(q_cfg_q);
			ST_SQQ: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			ST_TMUL: begin
				mul_a = t1_q;
				mul_b = quo_q;
			end
			ST_REDA: mul_b = pr_q;
			ST_REDB: mul_b = qr_q;
			ST_FMUL: begin
				mul_a = x_q;
				mul_b = t0_q;
			end
			default: ;
		endcase
		mul_ctl.start = go_q && (state_q != ST_DIV);
	end

	mrs_mulmod u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.modulus (m_q),
		.done    (mul_done),
		.result  (mul_res)
	);

	mrs_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go_q && (state_q == ST_DIV)),
		.dividend  (r0_q),
		.divisor   (r1_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
		end
	end

	// Next state and unit launches.
	always_comb begin
		state_d = state_q;
		go_d    = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				state_d = ST_SQP;
				go_d    = 1'b1;
			end
			ST_SQP: if (mul_done) begin
				if (mul_res == '0) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_REDQ;
					go_d    = 1'b1;
				end
			end
			ST_REDQ: if (mul_done) begin
				state_d = ST_SQQ;
				go_d    = 1'b1;
			end
			ST_SQQ: if (mul_done) state_d = ST_EUC;
			ST_EUC: begin
				go_d = 1'b1;
				if (r1_q != '0) begin
					state_d = ST_DIV;
				end else if (r0_q == WORD_W'(1)) begin
					state_d = ST_REDA;
				end else begin
					state_d = ST_FIN;
					go_d    = 1'b0;
				end
			end
			ST_DIV: if (div_done) begin
				state_d = ST_TMUL;
				go_d    = 1'b1;
			end
			ST_TMUL: if (mul_done) state_d = ST_EUC;
			ST_REDA: if (mul_done) begin
				state_d = ST_REDB;
				go_d    = 1'b1;
			end
			ST_REDB: if (mul_done) begin
				state_d = ST_FMUL;
				go_d    = 1'b1;
			end
			ST_FMUL: if (mul_done) state_d = ST_FIN;
			ST_FIN: if (fin_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration register and output word valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cfg_q     <= 32'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) q_cfg_q <= cfg_wdata;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (fin_fire) out_valid_q <= 1'b1;
		end
	end

	// Working registers of the inverse and the final product.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_valid) begin
				p_q     <= prime_p[PRIME_BITS-1:0];
				pr_q    <= p_root;
				qr_q    <= q_root;
				noinv_q <= 1'b0;
				res_q   <= '0;
			end
			ST_SQP: if (mul_done) begin
				m_q <= mul_res;
				if (mul_res == '0) noinv_q <= 1'b1;
			end
			ST_REDQ: if (mul_done) x_q <= mul_res;
			ST_SQQ: if (mul_done) begin
				r0_q <= m_q;
				r1_q <= mul_res;
				t0_q <= '0;
				t1_q <= one;
			end
			ST_EUC: if (r1_q == '0 && r0_q != WORD_W'(1)) noinv_q <= 1'b1;
			ST_DIV: if (div_done) begin
				quo_q <= div_quo;
				rem_q <= div_rem;
			end
			ST_TMUL: if (mul_done) begin
				r0_q <= r1_q;
				r1_q <= rem_q;
				t0_q <= t1_q;
				t1_q <= sub_mod(t0_q, mul_res, m_q);
			end
			ST_REDA: if (mul_done) x_q <= mul_res;
			ST_REDB: if (mul_done) x_q <= sub_mod(x_q, mul_res, m_q);
			ST_FMUL: if (mul_done) res_q <= mul_res;
			ST_FIN: if (fin_fire) begin
				out_root_q  <= res_q;
				out_noinv_q <= noinv_q;
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign shifted_root = out_root_q;
	assign no_inverse   = out_noinv_q;

	// The multiplier only reports completion to a state that launched it.
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_SQP || state_q == ST_REDQ || state_q == ST_SQQ ||
			state_q == ST_TMUL || state_q == ST_REDA || state_q == ST_REDB ||
			state_q == ST_FMUL))
		else $error("multiplier done outside a multiply state");

	// The divider only reports completion during the divide step.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider done outside the divide state");

	// An accepted word starts the squaring of p.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_SQP && go_q))
		else $error("accepted word did not start the sequencer");

	// A missing inverse always comes with a zero root.
	a_noinv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && no_inverse) |-> shifted_root == '0)
		else $error("nonzero root with no inverse");

endmodule

// ----- test/mrs_checker.sv -----
// Checker for the modular root shift block: predicts each result and compares it.
module mrs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] prime_p,
	input  logic [63:0] p_root,
	input  logic [63:0] q_root,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [63:0] shifted_root,
	input  logic        no_inverse,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          noinv_seen
);

	typedef struct {
		logic [63:0] root;
		logic        noinv;
	} shift_result_t;

	shift_result_t expected_roots[$];
	logic [31:0]   q_reg;
	int            err_cnt = 0;
	int            chk_cnt = 0;
	int            noinv_cnt = 0;

	// Computes the root difference times the inverse of q squared, modulo p squared.
	function automatic shift_result_t shift_root(input logic [31:0] q, input logic [31:0] p,
		input logic [63:0] pr, input logic [63:0] qr);
		shift_result_t      r;
		logic [63:0]        m;
		logic [63:0]        q2;
		logic [63:0]        a;
		logic [63:0]        b;
		logic [63:0]        diff;
		logic signed [129:0] r0, r1, t0, t1, quo, tmp;
		r.root  = '0;
		r.noinv = 1'b1;
		m = {32'b0, p} * {32'b0, p};
		if (m == 0) begin
			return r;
		end
		q2 = ({32'b0, q} * {32'b0, q}) % m;
		r0 = {66'b0, m};
		r1 = {66'b0, q2};
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			quo = r0 / r1;
			tmp = r0 - quo * r1;
			r0  = r1;
			r1  = tmp;
			tmp = t0 - quo * t1;
			t0  = t1;
			t1  = tmp;
		end
		if (r0 != 1) begin
			return r;
		end
		t0 = t0 % $signed({66'b0, m});
		if (t0 < 0) begin
			t0 = t0 + $signed({66'b0, m});
		end
		a = pr % m;
		b = qr % m;
		diff = (a >= b) ? (a - b) : (a + (m - b));
		r.root  = 64'(({64'b0, diff} * t0[127:0]) % {64'b0, m});
		r.noinv = 1'b0;
		return r;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		err_cnt++;
	endtask

	assign errors     = err_cnt;
	assign checked    = chk_cnt;
	assign noinv_seen = noinv_cnt;
	assign pending    = expected_roots.size();

	// Track the register, queue predictions, and compare each accepted word.
	always @(posedge clk or negedge arst_n) begin
		shift_result_t e;
		if (!arst_n) begin
			q_reg = 32'd1;
			expected_roots.delete();
		end else begin
			if (in_valid && in_ready) begin
				expected_roots.push_back(shift_root(q_reg, prime_p, p_root, q_root));
			end
			if (out_valid && out_ready) begin
				if (expected_roots.size() == 0) begin
					report("result word with no expectation waiting");
				end else begin
					e = expected_roots.pop_front();
					chk_cnt++;
					if (e.noinv) begin
						noinv_cnt++;
					end
					if (shifted_root !== e.root) begin
						report($sformatf("shifted_root got %h expected %h", shifted_root, e.root));
					end
					if (no_inverse !== e.noinv) begin
						report($sformatf("no_inverse got %b expected %b", no_inverse, e.noinv));
					end
				end
			end
			if (cfg_we) begin
				q_reg = cfg_wdata;
			end
		end
	end

endmodule

// ----- test/modular_root_shift_by_inverse_square_tb.sv -----
// Top of the modular root shift testbench: clock, reset, stimulus and verdict.
module modular_root_shift_by_inverse_square_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [31:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] prime_p;
	logic [63:0] p_root;
	logic [63:0] q_root;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] shifted_root;
	logic        no_inverse;
	int          errors, pending, checked, noinv_seen;
	int          hold_cycles;
	longint      cycles;

	modular_root_shift_by_inverse_square dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .prime_p(prime_p),
		.p_root(p_root), .q_root(q_root), .out_valid(out_valid),
		.out_ready(out_ready), .shifted_root(shifted_root), .no_inverse(no_inverse)
	);

	mrs_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .prime_p(prime_p),
		.p_root(p_root), .q_root(q_root), .out_valid(out_valid),
		.out_ready(out_ready), .shifted_root(shifted_root), .no_inverse(no_inverse),
		.errors(errors), .pending(pending), .checked(checked), .noinv_seen(noinv_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Run limit, counted in cycles.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 64'd60_000_000) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ready = 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ready = 1'b0;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				out_ready = (stall == 0);
			end
		end
	end

	// Offers one word and holds it until accepted; called at a falling edge.
	task automatic send_word(input logic [31:0] p, input logic [63:0] pr, input logic [63:0] qr);
		prime_p  = p;
		p_root   = pr;
		q_root   = qr;
		in_valid = 1'b1;
		while (!in_ready) begin
			@(negedge clk);
		end
		@(negedge clk);
		if (gap_len() > 0) begin
			in_valid = 1'b0;
			repeat (gap_len()) @(negedge clk);
		end
	endtask

	// Waits for every expected result, then writes the register.
	task automatic write_q(input logic [31:0] q);
		in_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (20) @(negedge clk);
		cfg_wdata = q;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Random word: mostly small primes to keep the Euclid run short.
	task automatic send_random();
		logic [31:0] p;
		logic [63:0] m, pr, qr;
		int          k;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			p = $urandom_range(2, 65535);
		end else if (k < 60) begin
			p = $urandom_range(2, 300);
		end else if (k < 63) begin
			p = $urandom_range(0, 1);
		end else begin
			p = $urandom;
		end
		m = {32'b0, p} * {32'b0, p};
		pr = rand64();
		qr = rand64();
		if (m != 0 && $urandom_range(0, 3) != 0) begin
			pr = pr % m;
			qr = qr % m;
		end
		send_word(p, pr, qr);
	endtask

	// Stimulus: directed cases, then random phases over several special-q values.
	initial begin
		logic [31:0] qs[8];
		int          n;
		qs = '{32'd3, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd2, 32'd0, 32'd0, 32'd0};
		for (int i = 5; i < 8; i++) begin
			qs[i] = $urandom_range(1, 65535) | 32'd1;
		end
		qs[7] = $urandom;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		prime_p = '0;
		p_root = '0;
		q_root = '0;
		hold_cycles = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words under the reset value of special-q.
		send_word(32'd5, 64'd24, 64'd3);
		send_word(32'd7, 64'd100, 64'd100);

		for (int ph = 0; ph < 8; ph++) begin
			write_q(qs[ph]);
			if (ph == 0) begin
				// Zero and one primes, multiples of q, extreme roots, wrapped difference.
				send_word(32'd0, 64'd1234, 64'd99);
				send_word(32'd1, '1, 64'd0);
				send_word(32'd2, 64'd3, 64'd1);
				send_word(32'd3, 64'd5, 64'd7);
				send_word(32'd6, 64'd1, 64'd2);
				send_word(32'hFFFF_FFFF, '1, '1);
				send_word(32'hFFFF_FFFB, 64'd0, '1);
				send_word(32'hFFFF_FFFF, 64'd0, 64'd1);
				send_word(32'd5, 64'd0, 64'd24);
				send_word(32'd65521, 64'd1 << 40, 64'd12345);
				send_word(32'hFFFF_FFFB, 64'hFFFF_FFF6_0000_0018, 64'd0);
			end else if (ph == 1) begin
				send_word(32'd1, 64'd7, 64'd9);
				send_word(32'd13, 64'd8, 64'd2);
			end else if (ph == 2) begin
				send_word(32'hFFFF_FFFB, '1, 64'd5);
				send_word(32'd2, 64'd0, 64'd3);
				// Long receiver hold-off while words keep coming.
				hold_cycles = 3000;
			end
			n = (ph < 3) ? 60 : 234;
			for (int i = 0; i < n; i++) begin
				send_random();
				if ($urandom_range(0, 99) == 0) begin
					in_valid = 1'b0;
					while (pending != 0) begin
						@(negedge clk);
					end
				end
			end
		end

		in_valid = 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (200) @(negedge clk);
		$display("Checked %0d shifted roots over 8 special-q settings, %0d without an inverse.",
			checked, noinv_seen);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
